// ----- sv/infix_to_postfix_converter_assert.svh -----
// Assertion macros shared by the infix-to-postfix converter modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ITP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("infix_to_postfix_converter: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ITP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("infix_to_postfix_converter: next-cycle check failed");

`endif

// ----- sv/itp_pkg.sv -----
// Package for the infix-to-postfix converter: character codes, symbol decode,
// precedence function and the command and status structs. No dependencies.
`timescale 1ns / 1ps

package itp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CH_FN_S  = 8'h53;
  localparam logic [7:0] CH_FN_C  = 8'h43;
  localparam logic [7:0] CH_FN_T  = 8'h54;
  localparam logic [7:0] CH_FN_O  = 8'h4F;
  localparam logic [7:0] CH_FN_A  = 8'h41;
  localparam logic [7:0] CH_FN_N  = 8'h4E;
  localparam logic [7:0] CH_FN_Q  = 8'h51;
  localparam logic [7:0] CH_FN_L  = 8'h4C;
  localparam logic [7:0] CH_FN_G  = 8'h47;

  typedef logic [2:0] prec_t;
  localparam prec_t PREC_OPEN = 3'd0;
  localparam prec_t PREC_ADD  = 3'd1;
  localparam prec_t PREC_MUL  = 3'd2;
  localparam prec_t PREC_FUNC = 3'd3;
  localparam prec_t PREC_POW  = 3'd4;
  localparam prec_t PREC_NONE = 3'd7;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_MINUS,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_OTHER
  } sym_class_t;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_MINUS,
    SRC_ITEM,
    SRC_TOP
  } sym_src_t;

  typedef struct packed {
    logic     load;
    logic     gen;
    logic     lead;
    logic     has;
    sym_src_t src;
    logic     trail;
    logic     pop;
    logic     push;
    logic     clr_first;
    logic     set_fault;
    logic     finish;
  } itp_cmd_t;

  typedef struct packed {
    sym_class_t cls;
    logic       empty;
    logic       top_open;
    logic       pop_ok;
    logic       first;
    logic       last;
    logic       can_gen;
    logic       out_free;
    logic       flush_due;
    logic       pend_valid;
  } itp_sts_t;

  function automatic sym_class_t classify(input logic [7:0] c);
    sym_class_t r;
    unique case (c) inside
      CH_TILDE:                             r = CLS_MINUS;
      CH_DOT, [CH_DIG0:CH_DIG9], [CH_LOW_A:CH_LOW_Z]: r = CLS_OPERAND;
      CH_OPEN:                              r = CLS_OPEN;
      CH_CLOSE:                             r = CLS_CLOSE;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET,
      CH_FN_S, CH_FN_C, CH_FN_T, CH_FN_O, CH_FN_A,
      CH_FN_N, CH_FN_Q, CH_FN_L, CH_FN_G:   r = CLS_OPER;
      default:                              r = CLS_OTHER;
    endcase
    return r;
  endfunction

  function automatic prec_t prec_of(input logic [7:0] c);
    prec_t r;
    unique case (c) inside
      CH_OPEN:                              r = PREC_OPEN;
      CH_PLUS, CH_MINUS:                    r = PREC_ADD;
      CH_STAR, CH_SLASH, CH_PCT:            r = PREC_MUL;
      CH_FN_S, CH_FN_C, CH_FN_T, CH_FN_O, CH_FN_A,
      CH_FN_N, CH_FN_Q, CH_FN_L, CH_FN_G:   r = PREC_FUNC;
      CH_CARET:                             r = PREC_POW;
      default:                              r = PREC_NONE;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/itp_datapath.sv -----
// Datapath of the infix-to-postfix converter: item registers, operator stack,
// pending result and output register. Depends on itp_pkg and the assert macros.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"

module itp_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       symbol,
  input  logic             last,
  input  itp_pkg::itp_cmd_t cmd,
  output itp_pkg::itp_sts_t sts,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             lead_space,
  output logic             has_symbol,
  output logic [7:0]       symbol_res,
  output logic             trail_space,
  output logic             run_end,
  output logic             expr_end,
  output logic             error
);

  logic [7:0]                 sym_r;
  logic                       last_r;
  logic                       fault;
  logic                       first;
  logic [7:0]                 stack [itp_pkg::STACK_DEPTH];
  logic [itp_pkg::CNT_W-1:0]  count;
  logic                       pend_valid;
  logic                       pend_lead;
  logic                       pend_has;
  logic [7:0]                 pend_sym;
  logic                       pend_trail;

  logic [itp_pkg::IDX_W-1:0]  top_idx;
  logic [7:0]                 top_sym;
  logic                       empty;
  logic                       full;
  logic                       out_free;
  logic [7:0]                 gen_sym;

  assign top_idx  = itp_pkg::IDX_W'(count - itp_pkg::CNT_W'(1));
  assign top_sym  = stack[top_idx];
  assign empty    = (count == '0);
  assign full     = (count == itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (cmd.src)
      itp_pkg::SRC_MINUS: gen_sym = itp_pkg::CH_MINUS;
      itp_pkg::SRC_ITEM:  gen_sym = sym_r;
      itp_pkg::SRC_TOP:   gen_sym = top_sym;
      default:            gen_sym = itp_pkg::CH_NUL;
    endcase
  end

  always_comb begin
    sts.cls        = itp_pkg::classify(sym_r);
    sts.empty      = empty;
    sts.top_open   = (top_sym == itp_pkg::CH_OPEN);
    sts.pop_ok     = !empty && (itp_pkg::prec_of(sym_r) <= itp_pkg::prec_of(top_sym));
    sts.first      = first;
    sts.last       = last_r;
    sts.can_gen    = !pend_valid || out_free;
    sts.out_free   = out_free;
    sts.flush_due  = pend_valid || last_r || fault;
    sts.pend_valid = pend_valid;
  end

  // Item registers and stack storage carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sym_r  <= symbol;
      last_r <= last;
    end
    if (cmd.push && !full) begin
      stack[count[itp_pkg::IDX_W-1:0]] <= sym_r;
    end
    if (cmd.gen) begin
      pend_lead  <= cmd.lead;
      pend_has   <= cmd.has;
      pend_sym   <= gen_sym;
      pend_trail <= cmd.trail;
    end
    if (cmd.gen && pend_valid) begin
      lead_space  <= pend_lead;
      has_symbol  <= pend_has;
      symbol_res  <= pend_sym;
      trail_space <= pend_trail;
      run_end     <= 1'b0;
      expr_end    <= 1'b0;
      error       <= 1'b0;
    end else if (cmd.finish && (pend_valid || last_r || fault)) begin
      lead_space  <= pend_valid && pend_lead;
      has_symbol  <= pend_valid && pend_has;
      symbol_res  <= pend_valid ? pend_sym : itp_pkg::CH_NUL;
      trail_space <= pend_valid && pend_trail;
      run_end     <= 1'b1;
      expr_end    <= last_r;
      error       <= fault;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault      <= 1'b0;
      first      <= 1'b0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        fault <= 1'b0;
        first <= 1'b1;
      end
      if (cmd.set_fault || (cmd.push && full)) begin
        fault <= 1'b1;
      end
      if (cmd.clr_first) begin
        first <= 1'b0;
      end
      if (cmd.push && !full) begin
        count <= count + itp_pkg::CNT_W'(1);
      end else if (cmd.pop) begin
        count <= count - itp_pkg::CNT_W'(1);
      end
      if (cmd.gen) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if ((cmd.gen && pend_valid) || (cmd.finish && (pend_valid || last_r || fault))) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ITP_ASSERT_NOW(a_pop_nonempty, clk, rst, cmd.pop, count != '0)
  `ITP_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= itp_pkg::CNT_W'(itp_pkg::STACK_DEPTH))
  `ITP_ASSERT_NEXT(a_flush_marks_end, clk, rst, cmd.finish && pend_valid, out_valid && run_end && !pend_valid)

endmodule

// ----- sv/itp_ctrl.sv -----
// Controller of the infix-to-postfix converter: sequences decode, pop runs,
// drain and the final flush. Depends on itp_pkg and the assert macros.
`timescale 1ns / 1ps
`include "infix_to_postfix_converter_assert.svh"

module itp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  itp_pkg::itp_sts_t sts,
  output itp_pkg::itp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CLOSE,
    ST_OPPOP,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  state_t after_item;

  assign in_stall   = (state != ST_IDLE);
  assign after_item = sts.last ? ST_DRAIN : ST_FINISH;

  always_comb begin
    cmd        = '0;
    cmd.src    = itp_pkg::SRC_NONE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts.cls) inside
          itp_pkg::CLS_MINUS, itp_pkg::CLS_OPERAND: begin
            if (sts.can_gen) begin
              cmd.gen    = 1'b1;
              cmd.has    = 1'b1;
              cmd.src    = (sts.cls == itp_pkg::CLS_MINUS) ? itp_pkg::SRC_MINUS
                                                           : itp_pkg::SRC_ITEM;
              state_next = after_item;
            end
          end
          itp_pkg::CLS_OPEN: begin
            cmd.push   = 1'b1;
            state_next = after_item;
          end
          itp_pkg::CLS_CLOSE: state_next = ST_CLOSE;
          itp_pkg::CLS_OPER:  state_next = ST_OPPOP;
          default:            state_next = after_item;
        endcase
      end
      ST_CLOSE: begin
        if (!sts.empty && !sts.top_open) begin
          if (sts.can_gen) begin
            cmd.gen   = 1'b1;
            cmd.lead  = 1'b1;
            cmd.has   = 1'b1;
            cmd.src   = itp_pkg::SRC_TOP;
            cmd.trail = 1'b1;
            cmd.pop   = 1'b1;
          end
        end else if (!sts.empty) begin
          // Matching open bracket: dropped without a result.
          cmd.pop    = 1'b1;
          state_next = after_item;
        end else if (sts.can_gen) begin
          // Stray close bracket: an empty result that carries the fault.
          cmd.gen       = 1'b1;
          cmd.set_fault = 1'b1;
          state_next    = after_item;
        end
      end
      ST_OPPOP: begin
        if (sts.pop_ok) begin
          if (sts.can_gen) begin
            cmd.gen       = 1'b1;
            cmd.lead      = sts.first;
            cmd.has       = 1'b1;
            cmd.src       = itp_pkg::SRC_TOP;
            cmd.trail     = 1'b1;
            cmd.pop       = 1'b1;
            cmd.clr_first = 1'b1;
          end
        end else if (sts.first) begin
          // Nothing was popped, so a spacer goes out before the push.
          if (sts.can_gen) begin
            cmd.gen    = 1'b1;
            cmd.lead   = 1'b1;
            cmd.push   = 1'b1;
            state_next = after_item;
          end
        end else begin
          cmd.push   = 1'b1;
          state_next = after_item;
        end
      end
      ST_DRAIN: begin
        if (!sts.empty) begin
          if (sts.can_gen) begin
            cmd.gen  = 1'b1;
            cmd.lead = 1'b1;
            cmd.has  = 1'b1;
            cmd.src  = itp_pkg::SRC_TOP;
            cmd.pop  = 1'b1;
          end
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.flush_due || sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `ITP_ASSERT_NOW(a_idle_no_pending, clk, rst, state == ST_IDLE, !sts.pend_valid)
  `ITP_ASSERT_NOW(a_no_push_and_pop, clk, rst, cmd.push, !cmd.pop)
  `ITP_ASSERT_NOW(a_gen_has_room, clk, rst, cmd.gen, sts.can_gen)

endmodule

// ----- sv/infix_to_postfix_converter.sv -----
// Infix-to-postfix converter (shunting yard), one coded symbol per transaction.
// Each symbol is loaded while idle and then decoded; an operator or close bracket then runs
// its pops, a final symbol drains the stack, and the finish step flushes the last result.
// A new symbol is taken only once the previous one is finished. The pop runs take
// one stack entry per cycle while the output does not stall.
// Reset (rst, synchronous, active high) empties the stack and clears all valid state.
`timescale 1ns / 1ps

// The design is split into a controller state machine (itp_ctrl) and a datapath
// (itp_datapath), joined only by a command struct and a status struct.
//
// The datapath keeps the accepted symbol, the operator stack (a register array
// indexed by the entry count), one pending result and the output register. Each
// generated result first lands in the pending register; it moves to the output
// when the next result is generated or when the symbol's work is finished. This
// lets the last result of a symbol carry run_end, expr_end and error without any
// lookahead into the stack.
//
// The input side takes a new transaction only while the controller is idle. The
// output register lets a finished result wait on out_stall while the controller
// keeps working on the pending one.
module infix_to_postfix_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       lead_space,
  output logic       has_symbol,
  output logic [7:0] symbol_res,
  output logic       trail_space,
  output logic       run_end,
  output logic       expr_end,
  output logic       error
);

  itp_pkg::itp_cmd_t cmd;
  itp_pkg::itp_sts_t sts;

  // Sequencing: decode, close-bracket pops, operator pops, drain and flush.
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and result formatting.
  itp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .symbol      (symbol),
    .last        (last),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .lead_space  (lead_space),
    .has_symbol  (has_symbol),
    .symbol_res  (symbol_res),
    .trail_space (trail_space),
    .run_end     (run_end),
    .expr_end    (expr_end),
    .error       (error)
  );

endmodule
